@@ rtl/core/euler_to_quaternion_top_assert.svh @@
// Assertion macros shared by the euler_to_quaternion RTL
`ifndef EULER_TO_QUATERNION_TOP_ASSERT_SVH
`define EULER_TO_QUATERNION_TOP_ASSERT_SVH

// cond must never hold outside reset
`define E2Q_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("e2q: forbidden condition");

// ante at a clock edge requires cons at the next edge
`define E2Q_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2q: expected follow-up missing");

`endif

@@ rtl/core/e2q_pkg.sv @@
// Package: widths, constants and table functions of the Euler-to-quaternion block
`default_nettype none
package e2q_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_W = 16;
  localparam int QUAT_W  = 16;
  localparam int TRIG_W  = 22;
  localparam int XY_W    = 34;
  localparam int Z_W     = 32;
  localparam int PAIR_W  = 2 * TRIG_W;
  localparam int HI_W    = PAIR_W - TRIG_W;
  localparam int SUM_W   = 64;

  localparam logic signed [Z_W-1:0] PI_Q28      = 32'sh3243F6A9;
  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 32'sh1921FB54;
  localparam logic signed [QUAT_W-1:0] Q_ONE    = 16'sd16384;
  localparam logic signed [QUAT_W-1:0] Q_MONE   = -16'sd16384;

  // shift-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem_v;
    quo = 64'd0;
    rem_v = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem_v = {rem_v[62:0], num[b]};
      if (rem_v >= den) begin
        rem_v = rem_v - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    longint unsigned diff;
    int k;
    pos = 64'd0;
    neg = 64'd0;
    k = 0;
    if (i == 0) begin
      return Z_W'((64'h3243F6A8885A308D + (64'd1 << 33)) >> 34);
    end
    for (int n = 1; n * i <= 60; n += 2) begin
      term = udiv64(64'd1 << (60 - n * i), 64'(n));
      if (k[0] == 1'b0) pos += term;
      else neg += term;
      k++;
    end
    diff = pos - neg;
    return Z_W'((diff + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic signed [XY_W-1:0] gain_q30(input int stages);
    longint unsigned k2;
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    k2 = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      k2 -= udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    v = k2;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return XY_W'(r);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/e2q_cordic.sv @@
// Pipelined rotation CORDIC: cosine and sine of half a Q3.12 angle, in Q.20
`default_nettype none
module e2q_cordic #(
  parameter int STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                clk,
  input  wire logic [STAGES+1:0]                   en,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
  output logic signed [e2q_pkg::TRIG_W-1:0]        cos_val,
  output logic signed [e2q_pkg::TRIG_W-1:0]        sin_val
);
  import e2q_pkg::*;

  localparam logic signed [XY_W-1:0] GAIN = gain_q30(STAGES);

  logic signed [XY_W-1:0] x [0:STAGES];
  logic signed [XY_W-1:0] y [0:STAGES];
  logic signed [Z_W-1:0]  z [0:STAGES];
  logic                   flip [0:STAGES];

  logic signed [Z_W-1:0]  z_in;
  logic signed [XY_W-1:0] x_rnd;
  logic signed [XY_W-1:0] y_rnd;
  logic signed [TRIG_W-1:0] c_q;
  logic signed [TRIG_W-1:0] s_q;

  assign z_in = {angle[ANGLE_W-1], angle, 15'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x[0] <= GAIN;
      y[0] <= '0;
      if (z_in > HALF_PI_Q28) begin
        z[0]    <= z_in - PI_Q28;
        flip[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Q28) begin
        z[0]    <= z_in + PI_Q28;
        flip[0] <= 1'b1;
      end else begin
        z[0]    <= z_in;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN = atan_q28(i);
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN;
        end
      end
    end
  end

  assign x_rnd = (x[STAGES] + XY_W'(512)) >>> 10;
  assign y_rnd = (y[STAGES] + XY_W'(512)) >>> 10;
  assign c_q   = x_rnd[TRIG_W-1:0];
  assign s_q   = y_rnd[TRIG_W-1:0];

  always_ff @(posedge clk) begin
    if (en[STAGES+1]) begin
      cos_val <= flip[STAGES] ? -c_q : c_q;
      sin_val <= flip[STAGES] ? -s_q : s_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/euler_to_quaternion_top.sv @@
// Top level: Euler angles to unit quaternion, fully pipelined
//
// Input channel: roll_angle, pitch_angle, yaw_angle (signed Q3.12 radians)
// with in_valid / in_stall; a transfer happens on a clock edge where
// in_valid is high and in_stall is low.
// Output channel: quat_x, quat_y, quat_z, quat_w (signed Q1.14, saturated
// to plus or minus one) with out_valid / out_stall, same transfer rule.
// Every input transfer gives exactly one output transfer, in order.
// Stages: one range fold stage, one CORDIC stage per iteration, a rounding
// stage, then pair products, split triple products, summation with rounding,
// and a saturating output register.
// Throughput is one item per cycle while out_stall is low.
// A stall holds the output register; upstream stages keep moving into empty
// slots, so in_stall rises only when every stage holds an item.
// Reset (rst, synchronous) empties the pipeline; payload is not cleared.
`default_nettype none
module euler_to_quaternion_top #(
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [e2q_pkg::QUAT_W-1:0]       quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]       quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]       quat_z,
  output logic signed [e2q_pkg::QUAT_W-1:0]       quat_w
);
  import e2q_pkg::*;

  localparam int CW    = CORDIC_STAGES + 2;
  localparam int S_PR  = CW;
  localparam int S_PP  = CW + 1;
  localparam int S_SUM = CW + 2;
  localparam int DEPTH = CW + 4;

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] en;

  logic signed [TRIG_W-1:0] cr, sr, cp, sp, cy, sy;

  logic signed [PAIR_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [TRIG_W-1:0] cr_d, sr_d;

  logic signed [PAIR_W-1:0] a_op [0:7];
  logic signed [TRIG_W-1:0] b_op [0:7];
  logic signed [PAIR_W-1:0]   ph [0:7];
  logic signed [PAIR_W+1:0]   pl [0:7];

  logic signed [SUM_W-1:0] sum [0:3];
  logic signed [SUM_W-1:0] rsum [0:3];
  logic signed [17:0]      q [0:3];
  logic signed [QUAT_W-1:0] qsat [0:3];

  assign en[DEPTH-1] = !vld[DEPTH-1] || !out_stall;
  for (genvar k = 0; k < DEPTH - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en[CW-1:0]), .angle(roll_angle), .cos_val(cr), .sin_val(sr)
  );
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en[CW-1:0]), .angle(pitch_angle), .cos_val(cp), .sin_val(sp)
  );
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en[CW-1:0]), .angle(yaw_angle), .cos_val(cy), .sin_val(sy)
  );

  always_ff @(posedge clk) begin
    if (en[S_PR]) begin
      p_cc <= cy * cp;
      p_ss <= sy * sp;
      p_sc <= sy * cp;
      p_cs <= cy * sp;
      cr_d <= cr;
      sr_d <= sr;
    end
  end

  // terms: x = cc*cr + ss*sr, y = sc*sr + cs*cr, z = sc*cr - cs*sr, w = cc*sr - ss*cr
  assign a_op[0] = p_cc;  assign b_op[0] = cr_d;
  assign a_op[1] = p_ss;  assign b_op[1] = sr_d;
  assign a_op[2] = p_sc;  assign b_op[2] = sr_d;
  assign a_op[3] = p_cs;  assign b_op[3] = cr_d;
  assign a_op[4] = p_sc;  assign b_op[4] = cr_d;
  assign a_op[5] = p_cs;  assign b_op[5] = sr_d;
  assign a_op[6] = p_cc;  assign b_op[6] = sr_d;
  assign a_op[7] = p_ss;  assign b_op[7] = cr_d;

  for (genvar t = 0; t < 8; t++) begin : g_pp
    logic signed [HI_W-1:0] a_hi;
    logic signed [TRIG_W:0] a_lo;
    assign a_hi = a_op[t][PAIR_W-1:TRIG_W];
    assign a_lo = {1'b0, a_op[t][TRIG_W-1:0]};
    always_ff @(posedge clk) begin
      if (en[S_PP]) begin
        ph[t] <= a_hi * b_op[t];
        pl[t] <= (PAIR_W+2)'(a_lo * b_op[t]);
      end
    end
  end

  for (genvar o = 0; o < 4; o++) begin : g_sum
    logic signed [PAIR_W:0]   h_c;
    logic signed [PAIR_W+2:0] l_c;
    if (o < 2) begin : g_add
      assign h_c = PAIR_W'(ph[2*o]) + PAIR_W'(ph[2*o+1]);
      assign l_c = pl[2*o] + pl[2*o+1];
    end else begin : g_sub
      assign h_c = PAIR_W'(ph[2*o]) - PAIR_W'(ph[2*o+1]);
      assign l_c = pl[2*o] - pl[2*o+1];
    end
    assign rsum[o] = (SUM_W'(h_c) <<< TRIG_W) + SUM_W'(l_c) + (SUM_W'(1) <<< 45);
    always_ff @(posedge clk) begin
      if (en[S_SUM]) sum[o] <= rsum[o] >>> 46;
    end
    assign q[o] = sum[o][17:0];
    assign qsat[o] = (q[o] > 18'sd16384)  ? Q_ONE  :
                     (q[o] < -18'sd16384) ? Q_MONE : q[o][QUAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[DEPTH-1]) begin
      quat_x <= qsat[0];
      quat_y <= qsat[1];
      quat_z <= qsat[2];
      quat_w <= qsat[3];
    end
  end

  `include "euler_to_quaternion_top_assert.svh"

  `E2Q_ASSERT_NEVER(a_stall_full, clk, rst, in_stall && !(&vld))
  `E2Q_ASSERT_NEXT(a_take_enters, clk, rst, in_valid && !in_stall, vld[0])
  `E2Q_ASSERT_NEVER(a_out_range, clk, rst, out_valid && (quat_x > Q_ONE || quat_x < Q_MONE || quat_w > Q_ONE || quat_w < Q_MONE))
  `E2Q_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(quat_y) && $stable(quat_z))

endmodule
`default_nettype wire

@@ bench/euler_to_quaternion_top_tb.sv @@
// Testbench for the Euler-angle to quaternion converter: random and directed angles, checked in order
`default_nettype none
module euler_to_quaternion_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = e2q_pkg::CORDIC_STAGES_DEF;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  class quat_scoreboard;
    quat_t pending[$];
    longint atan_tab[64];
    longint gain;
    int errors;

    function new();
      longint unsigned pos, neg, term, k2, v, r, b;
      int k;
      errors = 0;
      for (int i = 0; i < 31; i++) begin
        if (i == 0) begin
          atan_tab[i] = longint'((64'h3243F6A8885A308D + (64'd1 << 33)) >> 34);
        end else begin
          pos = 0;
          neg = 0;
          k = 0;
          for (int n = 1; n * i <= 60; n += 2) begin
            term = (64'd1 << (60 - n * i)) / longint'(n);
            if (k % 2 == 0) pos += term;
            else neg += term;
            k++;
          end
          atan_tab[i] = longint'((pos - neg + (64'd1 << 31)) >> 32);
        end
      end
      k2 = 64'd1 << 60;
      for (int i = 0; i < STAGES; i++) k2 -= k2 / ((64'd1 << (2 * i)) + 64'd1);
      v = k2;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      gain = longint'(r);
    endfunction

    function void half_trig(input logic signed [15:0] ang, output longint c,
                            output longint s);
      longint pi_q, hp, zz, xx, yy, dx, dy;
      bit flip;
      pi_q = longint'((64'h3243F6A8885A308D + (64'd1 << 31)) >> 32);
      hp = longint'((64'h3243F6A8885A308D + (64'd1 << 32)) >> 33);
      zz = longint'(ang) * 32768;
      xx = gain;
      yy = 0;
      flip = 0;
      if (zz > hp) begin
        zz -= pi_q;
        flip = 1;
      end else if (zz < -hp) begin
        zz += pi_q;
        flip = 1;
      end
      for (int i = 0; i < STAGES && i < 30; i++) begin
        dx = yy >>> i;
        dy = xx >>> i;
        if (zz >= 0) begin
          xx -= dx;
          yy += dy;
          zz -= atan_tab[i];
        end else begin
          xx += dx;
          yy -= dy;
          zz += atan_tab[i];
        end
      end
      xx = (xx + 512) >>> 10;
      yy = (yy + 512) >>> 10;
      c = flip ? -xx : xx;
      s = flip ? -yy : yy;
    endfunction

    function logic signed [15:0] round_sat(input longint sum);
      longint q;
      q = (sum + (longint'(1) << 45)) >>> 46;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return 16'(q);
    endfunction

    function void note_input(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                             input logic signed [15:0] yaw);
      longint cr, sr, cp, sp, cy, sy;
      quat_t q;
      half_trig(roll, cr, sr);
      half_trig(pitch, cp, sp);
      half_trig(yaw, cy, sy);
      q.x = round_sat(cy * cp * cr + sy * sp * sr);
      q.y = round_sat(sy * cp * sr + cy * sp * cr);
      q.z = round_sat(sy * cp * cr - cy * sp * sr);
      q.w = round_sat(cy * cp * sr - sy * sp * cr);
      pending.push_back(q);
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(input logic signed [15:0] x, input logic signed [15:0] y,
                      input logic signed [15:0] z, input logic signed [15:0] w);
      quat_t q;
      if (pending.size() == 0) begin
        report("output transfer with nothing pending");
      end else begin
        q = pending.pop_front();
        if (x !== q.x) report($sformatf("quat_x got %0d want %0d", x, q.x));
        if (y !== q.y) report($sformatf("quat_y got %0d want %0d", y, q.y));
        if (z !== q.z) report($sformatf("quat_z got %0d want %0d", z, q.z));
        if (w !== q.w) report($sformatf("quat_w got %0d want %0d", w, q.w));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] roll_angle = 0;
  logic signed [15:0] pitch_angle = 0;
  logic signed [15:0] yaw_angle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;

  quat_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;

  euler_to_quaternion_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(roll_angle, pitch_angle, yaw_angle);
      if (out_valid && !out_stall) sb.check_result(quat_x, quat_y, quat_z, quat_w);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // random stall bursts on the output side
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task send(input logic signed [15:0] r, input logic signed [15:0] p,
            input logic signed [15:0] y);
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    in_valid <= 1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task maybe_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function logic signed [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 200)) - 16'sd100;
      1: return 16'(16'($urandom_range(12860, 12875)) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] edges[10];
    edges = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd12867, 16'sd12868,
              -16'sd12867, -16'sd12868, 16'sd6434};
    repeat (6) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 10; i++) begin
      send(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
      maybe_gap();
    end
    send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send(-16'sh8000, -16'sh8000, -16'sh8000);
    send(16'sh5555, -16'sh2AAB, 16'sh0F00);
    for (int i = 0; i < 550; i++) begin
      if (i == 450) quiet = 1;
      send(pick_angle(), pick_angle(), pick_angle());
      if (i == 200) begin
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end else begin
        maybe_gap();
      end
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (STAGES + 12) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic.sv
rtl/core/euler_to_quaternion_top.sv
bench/euler_to_quaternion_top_tb.sv
